// ===== hdl/pmm_pkg.sv =====
// pmm_pkg: shared types, constants and helpers for the packed four-channel
// matrix multiply block
// no dependencies
package pmm_pkg;

    // default memory sizes, in 16-bit words
    localparam int SRC_WORDS_DEF    = 16384;
    localparam int WEIGHT_WORDS_DEF = 16384;

    // field widths
    localparam int WORD_W   = 16;
    localparam int PROD_W   = 32;
    localparam int ACC_W    = 40;
    localparam int SUM_W    = 32;
    localparam int ADDR_W   = 22;
    localparam int IDX_W    = 18;
    localparam int CFG_IX_W = 3;
    localparam int CFG_D_W  = 16;

    // request kinds carried in s_tuser
    typedef enum logic [1:0] {
        KIND_LOAD_SRC = 2'd0,
        KIND_LOAD_WGT = 2'd1,
        KIND_COMPUTE  = 2'd2
    } pmm_kind_t;

    // configuration register indexes
    typedef enum logic [CFG_IX_W-1:0] {
        CFG_WIDTH      = 3'd0,
        CFG_IN_BLOCKS  = 3'd1,
        CFG_OUT_BLOCKS = 3'd2,
        CFG_OUT_STRIDE = 3'd3,
        CFG_WEIGHT_GAP = 3'd4
    } pmm_cfg_idx_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } pmm_state_t;

    // clamp a 40-bit accumulator to signed 32 bits
    function automatic logic signed [SUM_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sh7FFF_FFFF);
        lo = -ACC_W'(64'sh8000_0000);
        if (v > hi)
        begin
            return {1'b0, {(SUM_W-1){1'b1}}};
        end
        else if (v < lo)
        begin
            return {1'b1, {(SUM_W-1){1'b0}}};
        end
        else
        begin
            return v[SUM_W-1:0];
        end
    endfunction

endpackage

// ===== hdl/packed4_matrix_multiply_top.sv =====
// packed4_matrix_multiply_top: source and weight word memories with a sequenced
// four-lane multiply-accumulate that forms one four-channel output pixel
// depends on pmm_pkg
//
// channel | direction | transaction contents
// s_*     | in        | tdata: mem_index, load_value, out_block, column; tuser: kind
// m_*     | out       | tdata: out_addr, sum0..sum3; tuser: error
// cfg_*   | in        | cfg_index selects register, cfg_data is written when cfg_we
//
// loads are accepted back to back while the block is idle
// a compute request passes setup, run, drain and done before the next acceptance,
// skipping run when the block or column is out of range or in_blocks is zero;
// run reads one source word per cycle and four weight banks keep pace
// reset clears control state and sets configuration to defaults; memory contents are undefined
// a stalled result holds the output register; the next request runs and waits done
module packed4_matrix_multiply_top
    import pmm_pkg::*;
#(
    parameter int SRC_WORDS    = SRC_WORDS_DEF,
    parameter int WEIGHT_WORDS = WEIGHT_WORDS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    // request stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [47:0]         s_tdata,   // mem_index[15:0], load_value[31:16],
                                           // out_block[37:32], column[45:38], zero pad
    input  logic [1:0]          s_tuser,   // kind[1:0]
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [151:0]        m_tdata,   // out_addr[21:0], sum0[53:22], sum1[85:54],
                                           // sum2[117:86], sum3[149:118], zero pad
    output logic [0:0]          m_tuser,   // error[0]
    // configuration writes
    input  logic                cfg_we,
    input  logic [CFG_IX_W-1:0] cfg_index,
    input  logic [CFG_D_W-1:0]  cfg_data
);

    localparam int SRC_AW   = $clog2(SRC_WORDS);
    localparam int WB_DEPTH = (WEIGHT_WORDS + 3) / 4;
    localparam int WB_AW    = $clog2(WB_DEPTH);

    // input field unpacking
    logic [15:0]              in_mem_index;
    logic signed [WORD_W-1:0] in_load_value;
    logic [5:0]               in_out_block;
    logic [7:0]               in_column;
    logic                     in_accept;

    assign in_mem_index  = s_tdata[15:0];
    assign in_load_value = s_tdata[31:16];
    assign in_out_block  = s_tdata[37:32];
    assign in_column     = s_tdata[45:38];
    assign in_accept     = s_tvalid && s_tready;

    // configuration registers
    logic [8:0]  width_reg;
    logic [6:0]  in_blocks_reg;
    logic [6:0]  out_blocks_reg;
    logic [15:0] out_stride_reg;
    logic [7:0]  weight_gap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= 9'd1;
            in_blocks_reg  <= 7'd1;
            out_blocks_reg <= 7'd1;
            out_stride_reg <= 16'd0;
            weight_gap_reg <= 8'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WIDTH:      width_reg      <= cfg_data[8:0];
                CFG_IN_BLOCKS:  in_blocks_reg  <= cfg_data[6:0];
                CFG_OUT_BLOCKS: out_blocks_reg <= cfg_data[6:0];
                CFG_OUT_STRIDE: out_stride_reg <= cfg_data[15:0];
                CFG_WEIGHT_GAP: weight_gap_reg <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    // sequencer state and counters
    pmm_state_t state_reg, state_next;
    logic [5:0]       ob_reg;
    logic [7:0]       col_reg;
    logic [IDX_W-1:0] sbase_reg;
    logic [IDX_W-1:0] wb_reg;
    logic [1:0]       lane_reg;
    logic [6:0]       blk_reg;
    logic             err_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic             rd_v_reg;
    logic             prod_v_reg;

    logic issue;
    logic load_out;
    logic setup_bad;
    logic last_issue;

    assign setup_bad  = (7'(ob_reg) >= out_blocks_reg) || (9'(col_reg) >= width_reg);
    assign last_issue = (lane_reg == 2'd3) && (blk_reg == (in_blocks_reg - 7'd1));
    assign s_tready   = (state_reg == ST_IDLE);

    // next state and control strobes
    always_comb
    begin
        state_next = state_reg;
        issue      = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (s_tuser == KIND_COMPUTE))
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (setup_bad || (in_blocks_reg == 7'd0))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                issue = 1'b1;
                if (last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_v_reg && !prod_v_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            lane_reg   <= 2'd0;
            blk_reg    <= 7'd0;
            err_reg    <= 1'b0;
            rd_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_v_reg   <= issue;
            prod_v_reg <= rd_v_reg;
            if (state_reg == ST_SETUP)
            begin
                lane_reg <= 2'd0;
                blk_reg  <= 7'd0;
                err_reg  <= setup_bad;
            end
            else if (issue)
            begin
                lane_reg <= lane_reg + 2'd1;
                if (lane_reg == 2'd3)
                begin
                    blk_reg <= blk_reg + 7'd1;
                end
                // overrun check once per input block
                if (lane_reg == 2'd0)
                begin
                    if ((({1'b0, sbase_reg} + 19'd3) >= 19'(SRC_WORDS)) ||
                        (({1'b0, wb_reg} + 19'd15) >= 19'(WEIGHT_WORDS)))
                    begin
                        err_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // request capture, base address multiplies and per-block address steps
    always_ff @(posedge clk)
    begin
        if (in_accept && (s_tuser == KIND_COMPUTE))
        begin
            ob_reg  <= in_out_block;
            col_reg <= in_column;
        end
        if (state_reg == ST_SETUP)
        begin
            wb_reg    <= IDX_W'(ob_reg) *
                         (IDX_W'({in_blocks_reg, 4'b0000}) + IDX_W'(weight_gap_reg));
            addr_reg  <= ADDR_W'(ob_reg) * ADDR_W'(out_stride_reg) +
                         ADDR_W'({col_reg, 2'b00});
            sbase_reg <= IDX_W'({col_reg, 2'b00});
        end
        else if (issue && (lane_reg == 2'd3))
        begin
            sbase_reg <= sbase_reg + IDX_W'({width_reg, 2'b00});
            wb_reg    <= wb_reg + IDX_W'(16);
        end
    end

    // source memory, one word per cycle
    logic signed [WORD_W-1:0] src_mem [SRC_WORDS];
    logic signed [WORD_W-1:0] src_q_reg;
    logic [IDX_W-1:0]         src_raddr;

    assign src_raddr = sbase_reg + IDX_W'(lane_reg);

    always_ff @(posedge clk)
    begin
        if (in_accept && (s_tuser == KIND_LOAD_SRC) && ({1'b0, in_mem_index} < 17'(SRC_WORDS)))
        begin
            src_mem[in_mem_index[SRC_AW-1:0]] <= in_load_value;
        end
        src_q_reg <= src_mem[src_raddr[SRC_AW-1:0]];
    end

    // weight memory in four banks by word index modulo four, so four
    // consecutive words come out in one cycle
    logic signed [WORD_W-1:0] wgt_mem [4][WB_DEPTH];
    logic signed [WORD_W-1:0] wgt_q_reg [4];
    logic [IDX_W-1:0]         wgt_start;
    logic [WB_AW-1:0]         wgt_raddr [4];

    assign wgt_start = wb_reg + IDX_W'({lane_reg, 2'b00});

    always_comb
    begin
        logic [1:0]       off;
        logic [IDX_W-1:0] idx;
        for (int b = 0; b < 4; b++)
        begin
            off          = 2'(b) - wgt_start[1:0];
            idx          = wgt_start + IDX_W'(off);
            wgt_raddr[b] = idx[WB_AW+1:2];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < 4; b++)
        begin
            if (in_accept && (s_tuser == KIND_LOAD_WGT) &&
                ({1'b0, in_mem_index} < 17'(WEIGHT_WORDS)) && (in_mem_index[1:0] == 2'(b)))
            begin
                wgt_mem[b][in_mem_index[WB_AW+1:2]] <= in_load_value;
            end
            wgt_q_reg[b] <= wgt_mem[b][wgt_raddr[b]];
        end
    end

    // lane products, registered
    logic signed [PROD_W-1:0] prod_reg [4];

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 4; j++)
        begin
            prod_reg[j] <= src_q_reg * wgt_q_reg[2'(wb_reg[1:0] + 2'(j))];
        end
    end

    // lane accumulators
    logic signed [ACC_W-1:0] acc_reg [4];

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 4; j++)
        begin
            if (state_reg == ST_SETUP)
            begin
                acc_reg[j] <= '0;
            end
            else if (prod_v_reg)
            begin
                acc_reg[j] <= acc_reg[j] + ACC_W'(prod_reg[j]);
            end
        end
    end

    // output register
    logic                     out_valid_reg;
    logic [ADDR_W-1:0]        out_addr_reg;
    logic signed [SUM_W-1:0]  out_sum_reg [4];
    logic                     out_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_addr_reg <= addr_reg;
            out_err_reg  <= err_reg;
            for (int j = 0; j < 4; j++)
            begin
                out_sum_reg[j] <= err_reg ? '0 : sat32(acc_reg[j]);
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_sum_reg[3], out_sum_reg[2], out_sum_reg[1],
                       out_sum_reg[0], out_addr_reg};
    assign m_tuser  = out_err_reg;

    // an error result carries zero sums
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[149:22] == '0))
        else $error("error result with nonzero sums");

    // memory read data only in flight while running or draining
    a_rd_window: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_v_reg || prod_v_reg) |-> ((state_reg == ST_RUN) || (state_reg == ST_DRAIN)))
        else $error("read pipeline active outside run or drain");

    // lane counter wraps back to zero by the end of each run
    a_lane_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (lane_reg == 2'd0))
        else $error("lane counter not aligned at idle");

    // a finished result reaches the output register
    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && (!m_tvalid || m_tready)) |=> (m_tvalid && (state_reg == ST_IDLE)))
        else $error("result not delivered to output register");

    // a compute request starts the setup step
    a_compute_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (s_tuser == KIND_COMPUTE)) |=> (state_reg == ST_SETUP))
        else $error("compute request did not start setup");

endmodule
